// ===== sv/crsc_pkg.sv =====
// Shared types and constants for the column-to-row span converter.
// No dependencies; every other file of the block except crsc_ram imports this package.
`default_nettype none

package crsc_pkg;

    // Geometry
    localparam int ROWS    = 64;
    localparam int COLUMNS = 512;

    // Field widths
    localparam int COL_W  = 9;
    localparam int TOP_W  = 7;
    localparam int ROW_W  = 6;
    localparam int CNT_W  = $clog2(ROWS + 1);
    localparam int CALC_W = 8;

    // Stream word widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // Command queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // One classified column: four row runs to walk, in this order
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] fin;
        logic [ROW_W-1:0] ct_row;   // close at top, ascending
        logic [CNT_W-1:0] ct_cnt;
        logic [ROW_W-1:0] cb_row;   // close at bottom, descending
        logic [CNT_W-1:0] cb_cnt;
        logic [ROW_W-1:0] ot_row;   // open at top, ascending
        logic [CNT_W-1:0] ot_cnt;
        logic [ROW_W-1:0] ob_row;   // open at bottom, descending
        logic [CNT_W-1:0] ob_cnt;
    } span_cmd_t;

    // Status of the command queue
    typedef struct packed {
        logic                valid;
        logic                ready;
        logic [QCNT_W-1:0]   count;
    } q_status_t;

    // Status of the span walker
    typedef struct packed {
        logic busy;
        logic ram_we;
        logic ram_re;
    } bk_status_t;

endpackage

`default_nettype wire

// ===== sv/column_to_row_span_converter_core.sv =====
// Top level of the column-to-row span converter: classifier, command queue
// and span walker. Depends on crsc_pkg, crsc_front, crsc_queue, crsc_back.
`default_nettype none

// Columns enter left to right on the s_ stream; each closed row leaves as one
// word on the m_ stream (top closes ascending, then bottom closes descending),
// with tlast on the final span of a column. The span walker steps one closed
// or opened row of a column per cycle, holding a close while the output
// register is full and not taken, and takes the next command once the runs
// of the current one are spent. The single row-start RAM port pair sets this
// rate. A classifier register and a four-deep command queue let input keep
// flowing while the walker or the output stalls. The first span of a column
// passes the classifier register, the command queue, the walker command register
// and the registered start read. The start store needs no clearing: a row is
// always opened before it can be closed.
module column_to_row_span_converter_core
    import crsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // column[8:0], prev_top[15:9], prev_bottom[21:16], cur_top[28:22],
    // cur_bottom[34:29], zero pad [39:35]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // span_row[5:0], span_first[14:6], span_final[23:15]
    output logic [M_DATA_W-1:0]      m_tdata,
    // last_span
    output logic                     m_tlast
);

    span_cmd_t   push_cmd;
    span_cmd_t   pop_cmd;
    logic        push_valid;
    logic        q_pop;
    q_status_t   q_status;
    bk_status_t  bk_status;

    crsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (push_valid),
        .cmd_ready (q_status.ready),
        .cmd       (push_cmd)
    );

    crsc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push_valid),
        .din    (push_cmd),
        .pop    (q_pop),
        .dout   (pop_cmd),
        .status (q_status)
    );

    crsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_status.valid),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .status   (bk_status)
    );

    // Start store never reads and writes in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(bk_status.ram_we && bk_status.ram_re))
        else $error("span start store read and written together");

    // Walker touches the start store only while it holds a command
    assert property (@(posedge clk) disable iff (!rst_n)
        (bk_status.ram_we || bk_status.ram_re) |-> bk_status.busy)
        else $error("start store access while walker idle");

    // Queue occupancy never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QDEPTH))
        else $error("command queue overflow");

    // A new output word follows only from a start store read
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_tvalid)) |-> $past(bk_status.ram_re))
        else $error("span word without a start read");

endmodule

`default_nettype wire

// ===== sv/crsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crsc_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/crsc_front.sv =====
// Input stage: registers one column word and classifies it into row runs.
// Depends on crsc_pkg.
`default_nettype none

module crsc_front
    import crsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     cmd_valid,
    input  wire logic                cmd_ready,
    output span_cmd_t                cmd
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [S_DATA_W-1:0]  in_data_reg;

    logic [COL_W-1:0]  col;
    logic [CALC_W-1:0] t1, b1, t2, b2;
    logic [CALC_W-1:0] t1n, b1n_p1, t2n;
    logic [CALC_W-1:0] ct_end_p1, cb_lo, ot_end_p1, ob_lo;
    logic [CALC_W-1:0] ct_cnt, cb_cnt, ot_cnt, ob_cnt;
    logic              ct_on, cb_on, ot_on, ob_on;

    function automatic logic [CALC_W-1:0] clamp_bottom(input logic [ROW_W-1:0] v);
        logic [CALC_W-1:0] w;
        w = CALC_W'(v);
        if (w > CALC_W'(ROWS - 1))
        begin
            w = CALC_W'(ROWS - 1);
        end
        return w;
    endfunction

    // Accept a word whenever the holding register is free or drains now
    assign s_tready      = !in_valid_reg || cmd_ready;
    assign cmd_valid     = in_valid_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // Unpack fields
    assign col = in_data_reg[8:0];
    assign t1  = CALC_W'(in_data_reg[15:9]);
    assign b1  = clamp_bottom(in_data_reg[21:16]);
    assign t2  = CALC_W'(in_data_reg[28:22]);
    assign b2  = clamp_bottom(in_data_reg[34:29]);

    // Close rows at the top: t1 .. min(t2-1, b1)
    always_comb
    begin
        ct_on     = (t1 < t2) && (t1 <= b1);
        ct_end_p1 = (t2 < b1 + 1'b1) ? t2 : b1 + 1'b1;
        ct_cnt    = ct_on ? ct_end_p1 - t1 : '0;
        t1n       = t1 + ct_cnt;
    end

    // Close rows at the bottom: b1 down to max(b2+1, t1n)
    always_comb
    begin
        cb_on  = (b1 > b2) && (b1 >= t1n);
        cb_lo  = (b2 + 1'b1 > t1n) ? b2 + 1'b1 : t1n;
        cb_cnt = cb_on ? b1 + 1'b1 - cb_lo : '0;
        b1n_p1 = b1 + 1'b1 - cb_cnt;
    end

    // Open rows at the top: t2 .. min(t1n-1, b2)
    always_comb
    begin
        ot_on     = (t2 < t1n) && (t2 <= b2);
        ot_end_p1 = (t1n < b2 + 1'b1) ? t1n : b2 + 1'b1;
        ot_cnt    = ot_on ? ot_end_p1 - t2 : '0;
        t2n       = t2 + ot_cnt;
    end

    // Open rows at the bottom: b2 down to max(b1n+1, t2n)
    always_comb
    begin
        ob_on  = (b2 + 1'b1 > b1n_p1) && (b2 >= t2n);
        ob_lo  = (b1n_p1 > t2n) ? b1n_p1 : t2n;
        ob_cnt = ob_on ? b2 + 1'b1 - ob_lo : '0;
    end

    // Build the command
    always_comb
    begin
        cmd.col    = col;
        cmd.fin    = col - COL_W'(1);
        cmd.ct_row = t1[ROW_W-1:0];
        cmd.ct_cnt = ct_cnt[CNT_W-1:0];
        cmd.cb_row = b1[ROW_W-1:0];
        cmd.cb_cnt = cb_cnt[CNT_W-1:0];
        cmd.ot_row = t2[ROW_W-1:0];
        cmd.ot_cnt = ot_cnt[CNT_W-1:0];
        cmd.ob_row = b2[ROW_W-1:0];
        cmd.ob_cnt = ob_cnt[CNT_W-1:0];
    end

endmodule

`default_nettype wire

// ===== sv/crsc_queue.sv =====
// Short command queue between the classifier and the span walker.
// Depends on crsc_pkg.
`default_nettype none

module crsc_queue
    import crsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire span_cmd_t din,
    input  wire logic      pop,
    output span_cmd_t      dout,
    output q_status_t      status
);

    span_cmd_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign status.valid = (count_reg != '0);
    assign status.ready = (count_reg != QCNT_W'(QDEPTH));
    assign status.count = count_reg;
    assign dout         = entry_reg[rd_ptr_reg];

    assign do_push = push && status.ready;
    assign do_pop  = pop && status.valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== sv/crsc_back.sv =====
// Span walker: one row per cycle, closes may stall; reads span starts for
// closed rows, writes them for opened. Depends on crsc_pkg, crsc_ram.
`default_nettype none

module crsc_back
    import crsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire span_cmd_t           q_cmd,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast,
    output bk_status_t               status
);

    span_cmd_t          cmd_reg, cmd_next;
    logic               busy_reg, busy_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [ROW_W-1:0]   rd_row_reg;
    logic [COL_W-1:0]   rd_fin_reg;
    logic               rd_last_reg;

    logic               all_zero, is_ct, is_cb, is_ot, is_ob;
    logic               adv, close_go, load, ram_we, ram_re, close_last;
    logic [ROW_W-1:0]   waddr, raddr;
    logic [COL_W-1:0]   rdata;

    // Pick the current step by run priority
    always_comb
    begin
        all_zero = (cmd_reg.ct_cnt == '0) && (cmd_reg.cb_cnt == '0)
                && (cmd_reg.ot_cnt == '0) && (cmd_reg.ob_cnt == '0);
        is_ct = busy_reg && (cmd_reg.ct_cnt != '0);
        is_cb = busy_reg && (cmd_reg.ct_cnt == '0) && (cmd_reg.cb_cnt != '0);
        is_ot = busy_reg && (cmd_reg.ct_cnt == '0) && (cmd_reg.cb_cnt == '0)
             && (cmd_reg.ot_cnt != '0);
        is_ob = busy_reg && (cmd_reg.ct_cnt == '0) && (cmd_reg.cb_cnt == '0)
             && (cmd_reg.ot_cnt == '0) && (cmd_reg.ob_cnt != '0);
    end

    // Output register frees when empty or taken
    assign adv      = !rd_valid_reg || m_tready;
    assign close_go = (is_ct || is_cb) && adv;
    assign ram_re   = close_go;
    assign ram_we   = is_ot || is_ob;
    assign raddr    = is_ct ? cmd_reg.ct_row : cmd_reg.cb_row;
    assign waddr    = is_ot ? cmd_reg.ot_row : cmd_reg.ob_row;
    assign load     = q_valid && (!busy_reg || all_zero);
    assign q_pop    = load;

    // Mark the final close of a column
    assign close_last = (is_ct && (cmd_reg.ct_cnt == CNT_W'(1)) && (cmd_reg.cb_cnt == '0))
                     || (is_cb && (cmd_reg.cb_cnt == CNT_W'(1)));

    // Step the runs
    always_comb
    begin
        cmd_next  = cmd_reg;
        busy_next = busy_reg;
        if (load)
        begin
            cmd_next  = q_cmd;
            busy_next = 1'b1;
        end
        else if (busy_reg && all_zero)
        begin
            busy_next = 1'b0;
        end
        else if (is_ct && adv)
        begin
            cmd_next.ct_row = cmd_reg.ct_row + 1'b1;
            cmd_next.ct_cnt = cmd_reg.ct_cnt - 1'b1;
        end
        else if (is_cb && adv)
        begin
            cmd_next.cb_row = cmd_reg.cb_row - 1'b1;
            cmd_next.cb_cnt = cmd_reg.cb_cnt - 1'b1;
        end
        else if (is_ot)
        begin
            cmd_next.ot_row = cmd_reg.ot_row + 1'b1;
            cmd_next.ot_cnt = cmd_reg.ot_cnt - 1'b1;
        end
        else if (is_ob)
        begin
            cmd_next.ob_row = cmd_reg.ob_row - 1'b1;
            cmd_next.ob_cnt = cmd_reg.ob_cnt - 1'b1;
        end
    end

    assign rd_valid_next = adv ? close_go : rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Hold the command and the metadata of the word in flight
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (close_go)
        begin
            rd_row_reg  <= raddr;
            rd_fin_reg  <= cmd_reg.fin;
            rd_last_reg <= close_last;
        end
    end

    crsc_ram #(
        .WIDTH (COL_W),
        .DEPTH (ROWS)
    ) u_start_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (cmd_reg.col),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign m_tvalid = rd_valid_reg;
    assign m_tdata  = {rd_fin_reg, rdata, rd_row_reg};
    assign m_tlast  = rd_last_reg;

    assign status.busy   = busy_reg;
    assign status.ram_we = ram_we;
    assign status.ram_re = ram_re;

endmodule

`default_nettype wire
